>>> rtl/pls_pkg.sv
// Package for the permutohedral lattice splat block.
// Holds the request payload types and the fixed lift constants.
// No dependencies.
`default_nettype none

package pls_pkg;

  localparam int DIM = 5;
  localparam int D1  = DIM + 1;

  // Lift scale per coordinate: round(sqrt(2/3)/sqrt((k+1)(k+2)) * 2^20) * (DIM+1).
  localparam logic signed [22:0] SCALE6 [DIM] = '{
    23'sd3632376, 23'sd2097150, 23'sd1482912, 23'sd1148658, 23'sd937872
  };

  typedef struct packed {
    logic               first_point;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic signed [15:0] feature_4;
  } pls_point_t;

  typedef struct packed {
    logic [11:0] vertex_index;
    logic [15:0] weight;
    logic [2:0]  vertex_slot;
    logic        is_new_vertex;
    logic        table_full;
    logic        last_vertex;
  } pls_vertex_t;

endpackage

`default_nettype wire

>>> rtl/pls_if.sv
// Valid/ready channel interfaces for the lattice splat block.
// Depends on pls_pkg for the payload types.
`default_nettype none

interface pls_point_if
  import pls_pkg::*;
();
  logic       valid;
  logic       ready;
  pls_point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pls_vertex_if
  import pls_pkg::*;
();
  logic        valid;
  logic        ready;
  pls_vertex_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/permutohedral_lattice_splat.sv
// Permutohedral lattice splat: top level with sequencer, shared datapath and key table.
// Depends on pls_pkg and the channel interfaces in pls_if.sv.
//
// Usage. Feature points arrive as requests on the points channel; each one yields
// six vertex requests on the vertices channel, slot 0 first, the last one marked
// by last_vertex. A point with first_point set empties the lattice table first.
// Sequence. The sequencer walks one point through a shared datapath: lift
// multiplies, elevation sums, rounding, ranking, sum repair, barycentric
// accumulation and a closing step, in that order. Then, per vertex, the key and
// weight are built and the table is searched linearly through its single read
// port, one stored key per cycle, so the search grows with vertex_count and
// the linear search dominates on full tables.
// The points channel is ready only while no point is in progress.
// Reset. rst empties the table (the fill count is cleared) and returns to idle;
// the key memory itself needs no clearing, as only entries below the count are read.
// Stalls. A finished vertex request sits in the output register; while it waits
// the next vertex is computed and searched, and the sequencer holds before the
// output register until the receiver takes the waiting request.
`default_nettype none

module permutohedral_lattice_splat
  import pls_pkg::*;
#(
  parameter int TABLE_CAPACITY = 4096,
  parameter int KEY_COORD_BITS = 12
) (
  input  wire          clk,
  input  wire          rst,
  pls_point_if.sink    points,
  pls_vertex_if.source vertices
);

  localparam int AW  = 40;  // lifted coordinate width
  localparam int EW  = 42;  // elevated coordinate and weight-sum width
  localparam int QW  = 15;  // rounded lattice coordinate width
  localparam int KW  = KEY_COORD_BITS * DIM;
  localparam int CW  = $clog2(TABLE_CAPACITY + 1);
  localparam int TAW = $clog2(TABLE_CAPACITY);
  localparam logic signed [EW-1:0] M = EW'(64'sd6 <<< 28);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ESUM, S_ROUND, S_RANK, S_REPAIR, S_BARY, S_BFIX,
    S_KEY, S_SRCH, S_EMIT
  } state_t;

  state_t state;

  logic signed [15:0]   feat [DIM];
  logic signed [AW-1:0] a    [DIM];
  logic signed [EW-1:0] e    [D1];
  logic signed [EW-1:0] y    [D1];
  logic signed [QW-1:0] q    [D1];
  logic [2:0]           rk   [D1];
  logic signed [EW-1:0] bary [D1+1];
  logic signed [EW-1:0] sfx;
  logic signed [AW-1:0] aprev;
  logic signed [15:0]   s;
  logic [2:0]           step;
  logic [2:0]           rem;
  logic [CW-1:0]        count;
  logic [CW-1:0]        t;
  logic [CW-1:0]        pidx;
  logic                 pend;
  logic [KW-1:0]        key;
  logic [15:0]          wgt;
  logic [CW-1:0]        vidx;
  logic                 vnew;
  logic                 vfull;

  // Key table.
  logic [KW-1:0] keymem [TABLE_CAPACITY];
  logic [KW-1:0] rdata;
  logic          rd_en;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keymem[count[TAW-1:0]] <= key;
    end
    if (rd_en) begin
      rdata <= keymem[t[TAW-1:0]];
    end
  end

  // Lift multiply.
  logic signed [38:0] mul_p;
  assign mul_p = feat[step] * SCALE6[step];

  // Elevation: suffix sum minus j times the previous lifted coordinate.
  logic [2:0]           jm1;
  logic signed [AW-1:0] a_rd;
  logic signed [EW-1:0] sfx_n;
  logic signed [EW-1:0] jprod;
  assign jm1   = (step == 3'd0) ? 3'd0 : step - 3'd1;
  assign a_rd  = a[jm1];
  assign sfx_n = sfx + ((step == 3'(DIM)) ? '0 : EW'(aprev));
  assign jprod = EW'($signed({1'b0, step}) * a_rd);

  // Rounding to the nearest multiple of D1 * 2^28, ties down.
  logic signed [EW-1:0] e_rd;
  logic signed [EW-1:0] e_off;
  logic signed [13:0]   e_hi;
  logic [16:0]          xq;
  logic [33:0]          xq_p;
  logic signed [QW-1:0] q_n;
  logic signed [EW-1:0] y_n;
  assign e_rd  = e[step];
  assign e_off = e_rd + EW'(64'sd3 <<< 28) - EW'(1);
  assign e_hi  = e_off[EW-1:28];
  assign xq    = 17'($signed({{3{e_hi[13]}}, e_hi}) + 17'sd49152);
  assign xq_p  = xq * 17'd43691;
  assign q_n   = QW'($signed({1'b0, xq_p[33:18]}) - 17'sd8192);
  assign y_n   = e_rd - ((EW'(q_n) * EW'(6)) <<< 28);

  // Ranking: count how many others beat y[step].
  logic signed [EW-1:0] yk;
  logic [2:0]           rk_n;
  assign yk = y[step];
  always_comb begin
    rk_n = '0;
    for (int l = 0; l < D1; l++) begin
      if ((3'(l) > step && yk < y[l]) || (3'(l) < step && y[l] >= yk)) begin
        rk_n = rk_n + 3'd1;
      end
    end
  end

  // Sum repair for one coordinate.
  logic signed [15:0]   rki;
  logic signed [15:0]   rk_adj;
  logic signed [QW-1:0] q_adj;
  logic signed [EW-1:0] y_adj;
  logic [2:0]           rk_cl;
  assign rki = 16'($signed({1'b0, rk[step]}));
  always_comb begin
    rk_adj = rki;
    q_adj  = q[step];
    y_adj  = y[step];
    if (s > 0) begin
      if (rki >= 16'sd6 - s) begin
        q_adj  = q[step] - QW'(1);
        y_adj  = y[step] + M;
        rk_adj = rki + s - 16'sd6;
      end else begin
        rk_adj = rki + s;
      end
    end else if (s < 0) begin
      if (rki < -s) begin
        q_adj  = q[step] + QW'(1);
        y_adj  = y[step] - M;
        rk_adj = rki + s + 16'sd6;
      end else begin
        rk_adj = rki + s;
      end
    end
    if (rk_adj < 0) begin
      rk_cl = '0;
    end else if (rk_adj > 16'sd5) begin
      rk_cl = 3'(DIM);
    end else begin
      rk_cl = rk_adj[2:0];
    end
  end

  // Weight and key for the current vertex slot.
  logic signed [EW-1:0] b_rd;
  logic signed [EW-1:0] b_off;
  logic signed [29:0]   w_hi;
  logic [36:0]          w_p;
  logic [15:0]          w_n;
  logic [KW-1:0]        key_n;
  assign b_rd  = bary[rem];
  assign b_off = b_rd + EW'(12288);
  assign w_hi  = b_off[EW-1:12];
  assign w_p   = w_hi[18:0] * 19'd174763;
  always_comb begin
    if (w_hi < 0) begin
      w_n = '0;
    end else if (w_hi >= 30'sd393216) begin
      w_n = 16'hFFFF;
    end else begin
      w_n = w_p[35:20];
    end
  end
  always_comb begin
    logic signed [17:0] c;
    for (int i = 0; i < DIM; i++) begin
      c = 18'(q[i]) * 18'sd6;
      if (rk[i] <= 3'(DIM) - rem) begin
        c = c + 18'($signed({1'b0, rem}));
      end else begin
        c = c + 18'($signed({1'b0, rem})) - 18'sd6;
      end
      key_n[i*KEY_COORD_BITS +: KEY_COORD_BITS] = c[KEY_COORD_BITS-1:0];
    end
  end

  // Search control.
  logic hit;
  assign hit   = pend && (rdata == key);
  assign rd_en = (state == S_SRCH) && !hit && (t < count);
  assign wr_en = (state == S_SRCH) && !hit && !(t < count) &&
                 (count < CW'(TABLE_CAPACITY));

  assign points.ready = (state == S_IDLE);

  // A finished vertex moves into the output register once that register is free.
  logic emit_go;
  assign emit_go = (state == S_EMIT) && (!vertices.valid || vertices.ready);

  logic [31:0] vidx_ext;
  assign vidx_ext = 32'(vidx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      vertices.valid <= 1'b0;
      pend           <= 1'b0;
    end else begin
      if (emit_go) begin
        vertices.valid <= 1'b1;
      end else if (vertices.ready) begin
        vertices.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (points.valid) begin
            if (points.data.first_point) begin
              count <= '0;
            end
            feat[0] <= points.data.feature_0;
            feat[1] <= points.data.feature_1;
            feat[2] <= points.data.feature_2;
            feat[3] <= points.data.feature_3;
            feat[4] <= points.data.feature_4;
            step    <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          a[step] <= AW'(mul_p);
          if (step == 3'(DIM - 1)) begin
            step  <= 3'(DIM);
            sfx   <= '0;
            state <= S_ESUM;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_ESUM: begin
          sfx   <= sfx_n;
          aprev <= a_rd;
          e[step] <= (step == 3'd0) ? sfx_n : sfx_n - jprod;
          if (step == 3'd0) begin
            s     <= '0;
            state <= S_ROUND;
          end else begin
            step <= step - 3'd1;
          end
        end
        S_ROUND: begin
          q[step] <= q_n;
          y[step] <= y_n;
          s       <= s + 16'(q_n);
          if (step == 3'(DIM)) begin
            step  <= '0;
            state <= S_RANK;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_RANK: begin
          rk[step] <= rk_n;
          if (step == 3'(DIM)) begin
            step  <= '0;
            state <= S_REPAIR;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_REPAIR: begin
          rk[step] <= rk_cl;
          q[step]  <= q_adj;
          y[step]  <= y_adj;
          if (step == 3'(DIM)) begin
            step  <= '0;
            for (int b = 0; b <= D1; b++) begin
              bary[b] <= '0;
            end
            state <= S_BARY;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_BARY: begin
          bary[3'(DIM) - rk[step]] <= bary[3'(DIM) - rk[step]] + y[step];
          bary[3'(D1) - rk[step]]  <= bary[3'(D1) - rk[step]] - y[step];
          if (step == 3'(DIM)) begin
            state <= S_BFIX;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_BFIX: begin
          bary[0] <= bary[0] + M + bary[D1];
          rem     <= '0;
          state   <= S_KEY;
        end
        S_KEY: begin
          key   <= key_n;
          wgt   <= w_n;
          t     <= '0;
          pend  <= 1'b0;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (hit) begin
            vidx  <= pidx;
            vnew  <= 1'b0;
            vfull <= 1'b0;
            pend  <= 1'b0;
            state <= S_EMIT;
          end else if (t < count) begin
            pend <= 1'b1;
            pidx <= t;
            t    <= t + CW'(1);
          end else begin
            pend <= 1'b0;
            if (count < CW'(TABLE_CAPACITY)) begin
              vidx  <= count;
              vnew  <= 1'b1;
              vfull <= 1'b0;
              count <= count + CW'(1);
            end else begin
              vidx  <= '0;
              vnew  <= 1'b0;
              vfull <= 1'b1;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold until the output register is free.
          if (emit_go) begin
            vertices.data.vertex_index  <= vidx_ext[11:0];
            vertices.data.weight        <= wgt;
            vertices.data.vertex_slot   <= rem;
            vertices.data.is_new_vertex <= vnew;
            vertices.data.table_full    <= vfull;
            vertices.data.last_vertex   <= (rem == 3'(DIM));
            if (rem == 3'(DIM)) begin
              state <= S_IDLE;
            end else begin
              rem   <= rem + 3'd1;
              state <= S_KEY;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
